// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the capture buffer.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("capture buffer assertion failed");

// Check that a signal holds while its beat is stalled.
`define TCRB_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("capture buffer stalled beat changed");

`endif

// File: rtl/tcrb_pkg.sv
// Shared constants, codes and types of the trigger capture ring buffer.
// No dependencies; the files that use it refer to it by scoped names.
package tcrb_pkg;

  // Sizing of the ring store
  localparam int MAX_DEPTH  = 1024;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W = $clog2(MAX_DEPTH);
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);

  // Fixed field widths of the ports
  localparam int DEPTH_REG_W = 11;
  localparam int MODE_W      = 2;
  localparam int PRE_W       = 10;
  localparam int REQ_W       = 3;
  localparam int DIN_W       = 32;
  localparam int IDX_W       = 10;
  localparam int STATE_W     = 3;
  localparam int COUNT_OUT_W = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Width that holds both a depth register value and any count
  localparam int WIDE_W = (CNT_W > DEPTH_REG_W) ? CNT_W : DEPTH_REG_W;
  // Width of pointer plus index, the dividend of the remainder unit
  localparam int MOD_W  = WIDE_W + 1;

  localparam logic [DEPTH_REG_W-1:0] DEPTH_RST = 11'd1024;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [WIDE_W-1:0]     wide_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [DATA_WIDTH:0]   word_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_START  = 3'd0,
    REQ_STOP   = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_SAMPLE = 3'd3,
    REQ_READ   = 3'd4
  } req_e;

  // Capture phases, as reported in capture_state
  typedef enum logic [STATE_W-1:0] {
    PH_STOPPED   = 3'd0,
    PH_WAITING   = 3'd1,
    PH_RUNNING   = 3'd2,
    PH_TRIGGERED = 3'd3,
    PH_COMPLETE  = 3'd4
  } phase_e;

  // Trigger mode codes
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE   = 2'd2;

  // Request beat
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [DIN_W-1:0] sample_data;
    logic             trigger_hit;
    logic             scan_error;
    logic [IDX_W-1:0] read_index;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [STATE_W-1:0]     capture_state;
    logic                   stored;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   read_valid;
    logic [DIN_W-1:0]       read_data;
    logic                   read_trigger_mark;
    logic                   error_flag;
  } rsp_t;

  // Remainder unit control
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] dividend;
    cnt_t             divisor;
  } mod_req_t;

  typedef struct packed {
    logic done;
    cnt_t rem;
  } mod_rsp_t;

endpackage

// File: rtl/tcrb_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on tcrb_pkg for the payload structs.
interface tcrb_req_if;
  logic            valid;
  logic            ready;
  tcrb_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tcrb_rsp_if;
  logic            valid;
  logic            ready;
  tcrb_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/tcrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tcrb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data of the addressed entry when re_i is set
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/tcrb_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tcrb_pkg for widths and the control structs.
module tcrb_mod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcrb_pkg::mod_req_t  req_i,
  output tcrb_pkg::mod_rsp_t  rsp_o
);

  localparam int STEP_W = $clog2(tcrb_pkg::MOD_W + 1);

  logic                       busy_q, done_q;
  logic [STEP_W-1:0]          step_q;
  logic [tcrb_pkg::MOD_W-1:0] shift_q;
  tcrb_pkg::cnt_t             div_q, rem_q;
  logic [tcrb_pkg::CNT_W:0]   trial, diff;

  // Bring down the next dividend bit and try one subtract
  assign trial = {rem_q, shift_q[tcrb_pkg::MOD_W-1]};
  assign diff  = trial - {1'b0, div_q};

  // Track busy and the step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(tcrb_pkg::MOD_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands and the partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      shift_q <= req_i.dividend;
      div_q   <= req_i.divisor;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= shift_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_q <= tcrb_pkg::CNT_W'(diff);
      end else begin
        rem_q <= tcrb_pkg::CNT_W'(trial);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: rtl/trigger_capture_ring_buffer.sv
// Top level of the trigger capture ring buffer: request decode, capture
// state, ring store and result staging. Depends on tcrb_pkg, tcrb_if,
// tcrb_ram and tcrb_mod.
//
// Start, stop, clear, sample and unknown requests are answered from the idle
// state, and the block can take the next request in the following cycle
// unless the result had to be parked. A read goes through ST_RD, for the
// registered read port of the ring store, while the ring has not wrapped,
// and through ST_MOD and then ST_RD once it is full, since the oldest-first
// position is reduced modulo the depth by a remainder unit that retires one
// bit per cycle. Results go through an output register backed by one parking
// slot, so a stalled result sink holds up requests only once both are full.
// The store needs no clearing pass after reset: valid indices only reach written entries.
module trigger_capture_ring_buffer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcrb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcrb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  tcrb_req_if.sink                            req_i,
  tcrb_rsp_if.source                          rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD
  } st_e;

  // Configuration registers
  logic [tcrb_pkg::DEPTH_REG_W-1:0] depth_q;
  logic [tcrb_pkg::MODE_W-1:0]      mode_q;
  logic [tcrb_pkg::PRE_W-1:0]       pre_q;

  // Capture state
  st_e               st_q, st_d;
  tcrb_pkg::phase_e  phase_q, phase_d;
  tcrb_pkg::addr_t   wp_q, wp_d;
  tcrb_pkg::cnt_t    cnt_q, cnt_d;
  tcrb_pkg::cnt_t    post_q, post_d;
  logic              havep_q, havep_d;
  logic              err_q, err_d;

  // Result staging
  tcrb_pkg::rsp_t    out_q, out_d, pend_q, pend_d, res;
  logic              out_vld_q, out_vld_d, pend_vld_q, pend_vld_d;
  logic              produce, accept, out_fire;

  // Store and remainder unit ports
  logic                mem_we, mem_re;
  tcrb_pkg::addr_t     mem_waddr, mem_raddr;
  tcrb_pkg::word_t     mem_wdata, mem_rdata;
  tcrb_pkg::mod_req_t  mod_req;
  tcrb_pkg::mod_rsp_t  mod_rsp;

  // Derived values
  tcrb_pkg::wide_t   depth_w;
  tcrb_pkg::cnt_t    eff_d, c_q, c_d, dm1, pre_cl, post_hit;
  tcrb_pkg::cnt_t    wp_inc, cnt_sat, cnt_nx;
  tcrb_pkg::addr_t   wp_w, wp_nx;
  logic              rd_ok, wrapped;

  assign accept   = req_i.valid && req_i.ready;
  assign out_fire = out_vld_q && rsp_o.ready;
  assign req_i.ready = (st_q == ST_IDLE) && !pend_vld_q;
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  // Clamp the depth register to 1..MAX_DEPTH
  assign depth_w = tcrb_pkg::wide_t'(depth_q);
  always_comb begin
    if (depth_w == '0) begin
      eff_d = tcrb_pkg::cnt_t'(1);
    end else if (depth_w > tcrb_pkg::wide_t'(tcrb_pkg::MAX_DEPTH)) begin
      eff_d = tcrb_pkg::cnt_t'(tcrb_pkg::MAX_DEPTH);
    end else begin
      eff_d = tcrb_pkg::cnt_t'(depth_w);
    end
  end

  // Ring pointer and count advance for one write
  assign wp_w    = (tcrb_pkg::cnt_t'(wp_q) >= eff_d) ? '0 : wp_q;
  assign wp_inc  = tcrb_pkg::cnt_t'(wp_w) + 1'b1;
  assign wp_nx   = (wp_inc >= eff_d) ? '0 : tcrb_pkg::addr_t'(wp_inc);
  assign cnt_sat = (cnt_q > eff_d) ? eff_d : cnt_q;
  assign cnt_nx  = (cnt_sat < eff_d) ? cnt_sat + 1'b1 : cnt_sat;

  // Post-trigger length from the clamped pre-trigger count
  assign dm1      = eff_d - 1'b1;
  assign pre_cl   = (tcrb_pkg::wide_t'(pre_q) > tcrb_pkg::wide_t'(dm1)) ? dm1
                  : tcrb_pkg::cnt_t'(pre_q);
  assign post_hit = eff_d - pre_cl - 1'b1;

  // Read range check against the valid count
  assign c_q     = (cnt_q < eff_d) ? cnt_q : eff_d;
  assign rd_ok   = tcrb_pkg::wide_t'(req_i.payload.read_index) < tcrb_pkg::wide_t'(c_q);
  assign wrapped = (c_q >= eff_d);

  // Decode requests, update capture state and stage results
  always_comb begin
    logic mark;
    st_d       = st_q;
    phase_d    = phase_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    post_d     = post_q;
    havep_d    = havep_q;
    err_d      = err_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    produce    = 1'b0;
    res        = '0;
    mark       = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wp_w;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mod_req.start    = 1'b0;
    mod_req.dividend = tcrb_pkg::MOD_W'(wp_q) + tcrb_pkg::MOD_W'(req_i.payload.read_index);
    mod_req.divisor  = eff_d;

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.payload.req_type)
            tcrb_pkg::REQ_START: begin
              wp_d    = '0;
              cnt_d   = '0;
              havep_d = 1'b0;
              err_d   = 1'b0;
              phase_d = (mode_q == tcrb_pkg::MODE_FREE || mode_q == tcrb_pkg::MODE_SINGLE)
                      ? tcrb_pkg::PH_RUNNING : tcrb_pkg::PH_WAITING;
              produce = 1'b1;
            end
            tcrb_pkg::REQ_STOP: begin
              phase_d = tcrb_pkg::PH_STOPPED;
              produce = 1'b1;
            end
            tcrb_pkg::REQ_CLEAR: begin
              wp_d    = '0;
              cnt_d   = '0;
              havep_d = 1'b0;
              produce = 1'b1;
            end
            tcrb_pkg::REQ_SAMPLE: begin
              produce = 1'b1;
              if (phase_q == tcrb_pkg::PH_STOPPED || phase_q == tcrb_pkg::PH_COMPLETE) begin
                // drop the sample
              end else if (req_i.payload.scan_error) begin
                err_d   = 1'b1;
                phase_d = tcrb_pkg::PH_STOPPED;
              end else begin
                case (phase_q)
                  tcrb_pkg::PH_RUNNING: begin
                    if (mode_q == tcrb_pkg::MODE_SINGLE || cnt_nx >= eff_d) begin
                      phase_d = tcrb_pkg::PH_COMPLETE;
                    end
                  end
                  tcrb_pkg::PH_WAITING: begin
                    if (req_i.payload.trigger_hit && havep_q) begin
                      mark    = 1'b1;
                      post_d  = post_hit;
                      phase_d = (post_hit != '0) ? tcrb_pkg::PH_TRIGGERED
                              : tcrb_pkg::PH_COMPLETE;
                    end
                  end
                  tcrb_pkg::PH_TRIGGERED: begin
                    post_d = (post_q != '0) ? post_q - 1'b1 : post_q;
                    if (post_d == '0) begin
                      phase_d = tcrb_pkg::PH_COMPLETE;
                    end
                  end
                  default: begin
                  end
                endcase
                mem_we    = 1'b1;
                mem_wdata = {mark, tcrb_pkg::data_t'(req_i.payload.sample_data)};
                wp_d      = wp_nx;
                cnt_d     = cnt_nx;
                havep_d   = 1'b1;
                res.stored = 1'b1;
              end
            end
            tcrb_pkg::REQ_READ: begin
              if (!rd_ok) begin
                produce = 1'b1;
              end else if (!wrapped) begin
                mem_re    = 1'b1;
                mem_raddr = tcrb_pkg::addr_t'(req_i.payload.read_index);
                st_d      = ST_RD;
              end else begin
                mod_req.start = 1'b1;
                st_d          = ST_MOD;
              end
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      ST_MOD: begin
        // Issue the store read once the ring position is known
        if (mod_rsp.done) begin
          mem_re    = 1'b1;
          mem_raddr = tcrb_pkg::addr_t'(mod_rsp.rem);
          st_d      = ST_RD;
        end
      end
      ST_RD: begin
        produce               = 1'b1;
        res.read_valid        = 1'b1;
        res.read_data         = tcrb_pkg::DIN_W'(mem_rdata[tcrb_pkg::DATA_WIDTH-1:0]);
        res.read_trigger_mark = mem_rdata[tcrb_pkg::DATA_WIDTH];
        st_d                  = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // Status as left by this request
    c_d               = (cnt_d < eff_d) ? cnt_d : eff_d;
    res.capture_state = phase_d;
    res.sample_count  = tcrb_pkg::COUNT_OUT_W'(c_d);
    res.error_flag    = err_d;

    // Move parked result forward, or place the new one
    if (pend_vld_q) begin
      if (out_fire) begin
        out_d      = pend_q;
        pend_vld_d = 1'b0;
      end
    end else if (produce) begin
      if (!out_vld_q || out_fire) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        pend_d     = res;
        pend_vld_d = 1'b1;
      end
    end else if (out_fire) begin
      out_vld_d = 1'b0;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= tcrb_pkg::DEPTH_RST;
      mode_q  <= tcrb_pkg::MODE_FREE;
      pre_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcrb_pkg::CFG_DEPTH: depth_q <= cfg_data_i[tcrb_pkg::DEPTH_REG_W-1:0];
        tcrb_pkg::CFG_MODE:  mode_q  <= cfg_data_i[tcrb_pkg::MODE_W-1:0];
        tcrb_pkg::CFG_PRE:   pre_q   <= cfg_data_i[tcrb_pkg::PRE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold sequencer state, capture state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      phase_q    <= tcrb_pkg::PH_STOPPED;
      wp_q       <= '0;
      cnt_q      <= '0;
      post_q     <= '0;
      havep_q    <= 1'b0;
      err_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      pend_q     <= '0;
    end else begin
      st_q       <= st_d;
      phase_q    <= phase_d;
      wp_q       <= wp_d;
      cnt_q      <= cnt_d;
      post_q     <= post_d;
      havep_q    <= havep_d;
      err_q      <= err_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
      out_q      <= out_d;
      pend_q     <= pend_d;
    end
  end

  tcrb_ram #(
    .DEPTH (tcrb_pkg::MAX_DEPTH),
    .WIDTH (tcrb_pkg::DATA_WIDTH + 1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tcrb_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

endmodule

// File: rtl/tcrb_chk.sv
// Port-level checker of the capture buffer, bound to the top level.
// Depends on tcrb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcrb_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input tcrb_pkg::rsp_t rsp_payload_i
);

  logic read_clean;
  logic one_kind;
  logic count_ok;

  // Terms of the payload checks
  assign read_clean = (rsp_payload_i.read_data == '0) && !rsp_payload_i.read_trigger_mark;
  assign one_kind   = !(rsp_payload_i.stored && rsp_payload_i.read_valid);
  assign count_ok   = rsp_payload_i.sample_count
                      <= tcrb_pkg::COUNT_OUT_W'(tcrb_pkg::MAX_DEPTH);

  // Hold a stalled result beat
  `TCRB_ASSERT(a_rsp_valid_hold, (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
  `TCRB_ASSERT_HOLD(a_rsp_payload_hold, rsp_valid_i, rsp_ready_i, rsp_payload_i)

  // Invalid reads and non-read results carry no sample
  `TCRB_ASSERT(a_read_zero, (rsp_valid_i && !rsp_payload_i.read_valid) |-> read_clean)

  // A beat is never both a write and a read, and the count stays within the ring
  `TCRB_ASSERT(a_kind_count, rsp_valid_i |-> (one_kind && count_ok))

endmodule

bind trigger_capture_ring_buffer tcrb_chk u_tcrb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);
